// File: sv/lsct_pkg.sv
// Shared types and constants for the line sensor calibration and threshold block.
package lsct_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int LINE_W       = 7;
    localparam int SAMPLE_W     = 8;

    localparam logic [CH_W-1:0]     CH_LAST     = CH_W'(NUM_CHANNELS - 1);
    localparam logic [SAMPLE_W-1:0] THR_DEFAULT = 8'd150;
    localparam logic [SAMPLE_W-1:0] THR_SPECIAL = 8'd187;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_PRESS  = 1'b1;

    localparam logic [1:0] PHASE_NONE  = 2'd0;
    localparam logic [1:0] PHASE_LIGHT = 2'd1;
    localparam logic [1:0] PHASE_DARK  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MID,
        S_VEC,
        S_DONE
    } state_t;

    typedef enum logic {
        ALU_MID,
        ALU_GT
    } alu_op_t;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } lsct_in_t;

    typedef struct packed {
        logic [2:0]        next_channel;
        logic [LINE_W-1:0] line_vector;
        logic              vector_ready;
        logic              calibrating;
        logic [1:0]        calibration_phase;
    } lsct_out_t;

endpackage

// File: sv/line_sensor_calibrate_threshold.sv
// Top level: channel ring, calibration stores, sequencer and result register.
//
// One item (a sample for the current channel or a button press) is taken when the
// block is idle, and it gives exactly one result. A press or a sample that does not
// close the ring goes from idle straight to the done state. The sample on the last
// channel of a dark calibration pass, and the last sample of a normal scan, start a
// walk: the sequencer walks every channel through the one shared arithmetic unit,
// forming one threshold midpoint or one line-vector bit per cycle.
// A new item is taken while the previous result still waits in the output register;
// the block then holds its own result until that register is free.
module line_sensor_calibrate_threshold (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lsct_pkg::lsct_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output lsct_pkg::lsct_out_t m_payload
);
    import lsct_pkg::*;

    state_t              state_reg, state_next;
    logic [CH_W-1:0]     ch_reg;
    logic [CH_W-1:0]     k_reg;
    logic                calib_reg;
    logic [1:0]          phase_reg;
    logic [LINE_W-1:0]   line_reg;
    logic                vready_reg;
    logic                m_valid_reg;
    lsct_out_t           m_payload_reg;

    logic [SAMPLE_W-1:0] light_mem  [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] dark_mem   [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] thr_mem    [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] sample_mem [NUM_CHANNELS];

    logic                in_xfer;
    logic                out_free;
    logic                wrap;
    logic [CH_W-1:0]     ch_adv;
    logic                iter_en;
    logic                load_out;
    alu_op_t             alu_op;
    logic [SAMPLE_W-1:0] alu_a, alu_b, alu_res;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign wrap     = (ch_reg >= CH_LAST);
    assign ch_adv   = wrap ? '0 : ch_reg + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    if (s_payload.command == CMD_SAMPLE && calib_reg
                        && phase_reg == PHASE_DARK && ch_reg == CH_LAST) begin
                        state_next = S_MID;
                    end else if (s_payload.command == CMD_SAMPLE && !calib_reg && wrap) begin
                        state_next = S_VEC;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MID, S_VEC: begin
                if (k_reg == CH_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        iter_en  = 1'b0;
        load_out = 1'b0;
        alu_op   = ALU_MID;
        unique case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_MID:  iter_en = 1'b1;
            S_VEC: begin
                iter_en = 1'b1;
                alu_op  = ALU_GT;
            end
            S_DONE: load_out = out_free;
            default: ;
        endcase
    end

    assign alu_a = (alu_op == ALU_GT) ? sample_mem[k_reg] : light_mem[k_reg];
    assign alu_b = (alu_op == ALU_GT) ? thr_mem[k_reg]    : dark_mem[k_reg];

    lsct_alu u_alu (
        .op     (alu_op),
        .opa    (alu_a),
        .opb    (alu_b),
        .result (alu_res)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ch_reg      <= '0;
            k_reg       <= '0;
            calib_reg   <= 1'b0;
            phase_reg   <= PHASE_NONE;
            line_reg    <= '0;
            vready_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_xfer) begin
                k_reg      <= '0;
                vready_reg <= 1'b0;
                if (s_payload.command == CMD_PRESS) begin
                    ch_reg    <= '0;
                    calib_reg <= 1'b1;
                    phase_reg <= (phase_reg == PHASE_LIGHT) ? PHASE_DARK : PHASE_LIGHT;
                end else begin
                    ch_reg <= ch_adv;
                    if (calib_reg) begin
                        if (wrap) begin
                            calib_reg <= 1'b0;
                        end
                    end else begin
                        vready_reg <= wrap;
                    end
                end
            end else if (iter_en) begin
                k_reg <= k_reg + 1'b1;
                if (state_reg == S_VEC && 32'(k_reg) < LINE_W) begin
                    line_reg[k_reg] <= alu_res[0];
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // light, dark and threshold stores reset to known values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                light_mem[i] <= '0;
                dark_mem[i]  <= '0;
                thr_mem[i]   <= (i == 1 || i == 2) ? THR_SPECIAL : THR_DEFAULT;
            end
        end else begin
            if (in_xfer && s_payload.command == CMD_SAMPLE && calib_reg) begin
                if (phase_reg == PHASE_LIGHT) begin
                    light_mem[ch_reg] <= s_payload.sample;
                end else if (phase_reg == PHASE_DARK) begin
                    dark_mem[ch_reg] <= s_payload.sample;
                end
            end
            if (state_reg == S_MID) begin
                thr_mem[k_reg] <= alu_res;
            end
        end
    end

    // normal-mode samples: every entry is written before a scan reads it
    always_ff @(posedge aclk) begin
        if (in_xfer && s_payload.command == CMD_SAMPLE && !calib_reg) begin
            sample_mem[ch_reg] <= s_payload.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_payload_reg.next_channel      <= 3'(ch_reg);
            m_payload_reg.line_vector       <= line_reg;
            m_payload_reg.vector_ready      <= vready_reg;
            m_payload_reg.calibrating       <= calib_reg;
            m_payload_reg.calibration_phase <= phase_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // a press restarts the ring in calibration mode
    a_press_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_payload.command == CMD_PRESS) |=> (calib_reg && ch_reg == '0))
        else $error("press did not restart the ring in calibration");

    // a result is only loaded from the done state
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the done state");

    // the channel walk ends after the last channel
    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_MID || state_reg == S_VEC) && k_reg == CH_LAST)
        |=> state_reg == S_DONE)
        else $error("channel walk did not finish on the last channel");

    // a finished scan leaves the ring at channel 0 outside calibration
    a_vector_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.vector_ready)
        |-> (m_payload_reg.next_channel == 3'd0 && !m_payload_reg.calibrating))
        else $error("vector ready with ring not at its start");

endmodule

// File: sv/lsct_alu.sv
// Shared 8-bit arithmetic unit: threshold midpoint or sample-above-threshold compare.
module lsct_alu (
    input  lsct_pkg::alu_op_t                op,
    input  logic [lsct_pkg::SAMPLE_W-1:0]    opa,
    input  logic [lsct_pkg::SAMPLE_W-1:0]    opb,
    output logic [lsct_pkg::SAMPLE_W-1:0]    result
);
    import lsct_pkg::*;

    logic [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0] sum;
    logic              a_gt_b;

    // borrow of b - a is set exactly when a > b
    assign diff   = {1'b0, opb} - {1'b0, opa};
    assign a_gt_b = diff[SAMPLE_W];
    // a + (b - a) / 2 truncated toward zero == (a + b + (b < a)) >> 1
    assign sum    = {1'b0, opa} + {1'b0, opb} + {{SAMPLE_W{1'b0}}, a_gt_b};

    always_comb begin
        unique case (op)
            ALU_MID: result = sum[SAMPLE_W:1];
            ALU_GT:  result = {{(SAMPLE_W-1){1'b0}}, a_gt_b};
            default: result = '0;
        endcase
    end

endmodule

// File: sim/line_sensor_calibrate_threshold_tb.sv
// Self-checking testbench for the line sensor calibration and threshold block.
module line_sensor_calibrate_threshold_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsct_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_ITEMS_END = 1850;
    localparam int MAX_REPORTS      = 60;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    lsct_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    lsct_out_t m_payload;

    line_sensor_calibrate_threshold dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #2 aclk = ~aclk;

    // Sensor state as the block should hold it
    logic [2:0]          ring_ch;
    logic                cal_on;
    logic [1:0]          cal_phase;
    logic [SAMPLE_W-1:0] light_lvl [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] dark_lvl  [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] thr       [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] seen      [NUM_CHANNELS];
    logic [LINE_W-1:0]   line_bits;

    lsct_out_t expected_readings [$];

    int errors            = 0;
    int items_sent        = 0;
    int presses_sent      = 0;
    int vectors_formed    = 0;
    int threshold_updates = 0;
    int cycle_count       = 0;
    bit quiet             = 1'b0;
    int sink_hold_req     = 0;
    int hold_left         = 0;

    function automatic void sensor_reset();
        ring_ch   = '0;
        cal_on    = 1'b0;
        cal_phase = PHASE_NONE;
        line_bits = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            light_lvl[i] = '0;
            dark_lvl[i]  = '0;
            seen[i]      = '0;
            thr[i]       = (i == 1 || i == 2) ? THR_SPECIAL : THR_DEFAULT;
        end
    endfunction

    function automatic lsct_out_t sensor_step(input lsct_in_t it);
        lsct_out_t  r;
        logic       rdy;
        logic [2:0] ch;
        int         lo;
        int         hi;
        rdy = 1'b0;
        ch  = ring_ch;
        if (it.command == CMD_PRESS) begin
            presses_sent++;
            ring_ch   = '0;
            cal_on    = 1'b1;
            cal_phase = (cal_phase == PHASE_LIGHT) ? PHASE_DARK : PHASE_LIGHT;
        end else if (cal_on) begin
            if (cal_phase == PHASE_LIGHT) begin
                light_lvl[ch] = it.sample;
            end else if (cal_phase == PHASE_DARK) begin
                dark_lvl[ch] = it.sample;
                if (ch == CH_LAST) begin
                    threshold_updates++;
                    // midpoint, division truncates toward zero
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        lo     = light_lvl[i];
                        hi     = dark_lvl[i];
                        thr[i] = SAMPLE_W'(lo + (hi - lo) / 2);
                    end
                end
            end
            if (ch == CH_LAST) begin
                ring_ch = '0;
                cal_on  = 1'b0;
            end else begin
                ring_ch = ch + 3'd1;
            end
        end else begin
            seen[ch] = it.sample;
            if (ch == CH_LAST) begin
                ring_ch   = '0;
                line_bits = '0;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (i < LINE_W && seen[i] > thr[i]) line_bits[i] = 1'b1;
                end
                rdy = 1'b1;
                vectors_formed++;
            end else begin
                ring_ch = ch + 3'd1;
            end
        end
        r.next_channel      = ring_ch;
        r.line_vector       = line_bits;
        r.vector_ready      = rdy;
        r.calibrating       = cal_on;
        r.calibration_phase = cal_phase;
        return r;
    endfunction

    // Often near the current channel's threshold so vector bits toggle, else random or extreme
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int r;
        int t;
        r = $urandom_range(0, 9);
        t = int'(thr[ring_ch]) + int'($urandom_range(0, 6)) - 3;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        case (r)
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return SAMPLE_W'($urandom_range(0, 255));
            default:    return SAMPLE_W'(t);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic void check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want_v, got_v);
        end
    endfunction

    task automatic send_item(input lsct_in_t it);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        expected_readings.push_back(sensor_step(it));
        items_sent++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        lsct_in_t it;
        it.command = CMD_SAMPLE;
        it.sample  = v;
        send_item(it);
    endtask

    task automatic send_press();
        lsct_in_t it;
        it.command = CMD_PRESS;
        it.sample  = SAMPLE_W'($urandom_range(0, 255)); // don't care for a press
        send_item(it);
    endtask

    // Walk the ring until it wraps, in whatever mode the block is in
    task automatic finish_pass();
        do send_sample(next_sample()); while (ring_ch != 0);
    endtask

    task automatic hold_sender_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic test_default_thresholds();
        logic [SAMPLE_W-1:0] vals [NUM_CHANNELS];
        // equal-to-threshold must not set a bit
        vals = '{8'd150, 8'd188, 8'd187, 8'd151, 8'd0, 8'd255, 8'd149};
        for (int i = 0; i < NUM_CHANNELS; i++) send_sample(vals[i]);
    endtask

    task automatic test_two_point_calibration();
        logic [SAMPLE_W-1:0] lite [NUM_CHANNELS];
        logic [SAMPLE_W-1:0] drk  [NUM_CHANNELS];
        // dark above and below light with odd spans exercises truncation toward zero
        lite = '{8'd0,   8'd255, 8'd100, 8'd101, 8'd10, 8'd200, 8'd128};
        drk  = '{8'd255, 8'd0,   8'd101, 8'd100, 8'd11, 8'd201, 8'd128};
        send_press();
        for (int i = 0; i < NUM_CHANNELS; i++) send_sample(lite[i]);
        send_press();
        for (int i = 0; i < NUM_CHANNELS; i++) send_sample(drk[i]);
    endtask

    task automatic test_press_stepping();
        send_press();          // dark to light
        send_sample(8'hA5);
        send_press();          // light pass cut short, now dark
        send_press();          // dark back to light
    endtask

    task automatic test_output_backpressure();
        quiet         = 1'b1;
        sink_hold_req = 300;
        repeat (16) send_sample(next_sample());
        quiet = 1'b0;
        hold_sender_until_drained();
    endtask

    task automatic test_sender_pause();
        repeat (5) send_sample(next_sample());
        hold_sender_until_drained();
        repeat (5) send_sample(next_sample());
    endtask

    task automatic test_random_traffic();
        int pick;
        while (items_sent < RANDOM_ITEMS_END) begin
            quiet = ($urandom_range(0, 6) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 50) begin
                finish_pass();
            end else if (pick < 75) begin
                send_press();
                finish_pass();
                send_press();
                finish_pass();
            end else if (pick < 90) begin
                send_press();
                repeat ($urandom_range(0, 6)) send_sample(SAMPLE_W'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 3) == 0) send_press();
                    else send_sample(SAMPLE_W'($urandom_range(0, 255)));
                end
            end else begin
                hold_sender_until_drained();
            end
        end
        quiet = 1'b0;
    endtask

    // Result side: random ready, occasional long stalls, forced hold-off on request
    always @(negedge aclk) begin
        if (sink_hold_req != 0) begin
            hold_left     = sink_hold_req;
            sink_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 299) == 0) begin
            hold_left = $urandom_range(12, 40);
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 75);
        end
    end

    always @(posedge aclk) begin : result_check
        lsct_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, m_payload);
            end else begin
                want = expected_readings.pop_front();
                check_field("next_channel", want.next_channel, m_payload.next_channel);
                check_field("line_vector", want.line_vector, m_payload.line_vector);
                check_field("vector_ready", want.vector_ready, m_payload.vector_ready);
                check_field("calibrating", want.calibrating, m_payload.calibrating);
                check_field("calibration_phase", want.calibration_phase,
                            m_payload.calibration_phase);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_readings.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        sensor_reset();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_thresholds();
        test_two_point_calibration();
        test_press_stepping();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();

        hold_sender_until_drained();
        repeat (4 * (NUM_CHANNELS + 2)) @(posedge aclk);

        $display("Run covered %0d items with %0d button presses, %0d line vectors formed",
                 items_sent, presses_sent, vectors_formed);
        $display("and %0d threshold recalculations, under random stalls on both sides.",
                 threshold_updates);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
